>>> src/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked outside reset.
`define NPFF_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked at every edge, reset included.
`define NPFF_ASSERT_NEXT(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define NPFF_ASSERT_IMPL(lbl, clk, rst, a, c)
`define NPFF_ASSERT_NEXT(lbl, clk, a, c)
`endif
`endif

>>> src/npff_pkg.sv
// Types and constants of the face flux block.
package npff_pkg;

  localparam int IN_TDATA_W  = 296;
  localparam int OUT_TDATA_W = 80;
  localparam int Q_DEPTH     = 2;

  // Register indexes
  localparam logic REG_FLOW_VELOCITY = 1'b0;

  // Classified species word passed from front to back
  typedef struct packed {
    logic signed [32:0] ksi;
    logic signed [32:0] dc;
    logic signed [32:0] dphi;
    logic signed [31:0] cf;
    logic        [30:0] alpha;
    logic        [30:0] dcoef;
    logic signed [3:0]  z;
    logic               last;
    logic               derr;
  } q_item_t;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_PRE,
    BK_PROD,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } back_state_t;

endpackage

>>> src/nernst_planck_face_flux_top.sv
// Top level of the Nernst-Planck face flux block.
// Takes one species word per face-species pair and returns its saturated
// Q16.16 flux; on the word marked last it also returns the summed current
// density and clears that sum. Each species passes through the steps of the
// back-end sequencer and the one-bit-per-cycle divider that forms the
// diffusive quotient; a face with coincident centres skips the divider.
// The front end and a two-word queue keep accepting words while the back
// end works, until both are full. flow_velocity is to be written over the
// APB port only while the block is idle; the block itself does not enforce
// this.
module nernst_planck_face_flux_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // conc_left, conc_right, potential_left, potential_right, centre_left,
  // centre_right, perm_left, perm_right, diffusion_coeff, charge_number
  input  logic [npff_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,   // right_is_membrane
  input  logic                             s_tlast,   // last_species
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // species_flux, current_density
  output logic [npff_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tuser,   // distance_error
  output logic                             m_tlast,   // is_last
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import npff_pkg::*;

`include "assert_macros.svh"

  logic signed [31:0] flow_velocity;
  logic               push_valid, push_ready, q_valid, q_pop;
  q_item_t            push_data, q_data;
  logic [1:0]         q_count;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FLOW_VELOCITY) ? flow_velocity : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_velocity <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_FLOW_VELOCITY) begin
      flow_velocity <= $signed(pwdata);
    end
  end

  npff_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .push_valid, .push_ready, .push_data
  );

  npff_queue u_queue (
    .clk, .rst, .push_valid, .push_ready, .push_data,
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_data), .count(q_count)
  );

  npff_div u_div (
    .clk, .rst, .req(div_req), .rsp(div_rsp)
  );

  npff_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .flow_velocity, .q_valid, .q_pop, .q_data,
    .div_req, .div_rsp, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  `NPFF_ASSERT_IMPL(a_cd_only_last, clk, rst, m_tvalid && !m_tlast, m_tdata[79:32] == '0)
  `NPFF_ASSERT_IMPL(a_q_bound, clk, rst, 1'b1, q_count <= 2'(Q_DEPTH))
  `NPFF_ASSERT_IMPL(a_pop_nonempty, clk, rst, q_pop, q_count != 2'd0)
  `NPFF_ASSERT_NEXT(a_rst_idle, clk, rst, !m_tvalid && q_count == 2'd0)

endmodule

>>> src/npff_front.sv
// Front end: accepts species words, forms differences and classifies them.
module npff_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // conc_left, conc_right, potential_left, potential_right, centre_left,
  // centre_right, perm_left, perm_right, diffusion_coeff, charge_number
  input  logic [npff_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,   // right_is_membrane
  input  logic                             s_tlast,   // last_species
  output logic                             push_valid,
  input  logic                             push_ready,
  output npff_pkg::q_item_t                push_data
);
  import npff_pkg::*;

  logic signed [31:0] cl, cr, pl, pr, xl, xr;
  logic signed [32:0] csum;
  logic               hold_valid;
  q_item_t            item;

  // Unpack fields
  assign cl = $signed(s_tdata[31:0]);
  assign cr = $signed(s_tdata[63:32]);
  assign pl = $signed(s_tdata[95:64]);
  assign pr = $signed(s_tdata[127:96]);
  assign xl = $signed(s_tdata[159:128]);
  assign xr = $signed(s_tdata[191:160]);

  // Classify the word
  always_comb begin
    csum       = 33'(cl) + 33'(cr);
    item.ksi   = 33'(xr) - 33'(xl);
    item.dc    = 33'(cr) - 33'(cl);
    item.dphi  = 33'(pr) - 33'(pl);
    item.cf    = csum[32:1];
    item.alpha = s_tuser ? s_tdata[253:223] : s_tdata[222:192];
    item.dcoef = s_tdata[284:254];
    item.z     = $signed(s_tdata[288:285]);
    item.last  = s_tlast;
    item.derr  = (xr == xl);
  end

  assign s_tready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;

  // Hold one classified word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      push_data <= item;
    end
  end

endmodule

>>> src/npff_queue.sv
// Short queue between front and back.
module npff_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  npff_pkg::q_item_t push_data,
  output logic              pop_valid,
  input  logic              pop,
  output npff_pkg::q_item_t pop_data,
  output logic [1:0]        count
);
  import npff_pkg::*;

  q_item_t mem [Q_DEPTH];
  logic    wr_ptr, rd_ptr;
  logic    do_push;

  assign push_ready = (count != 2'(Q_DEPTH));
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> src/npff_div.sv
// Radix-2 signed divider, quotient truncated toward zero, one bit a cycle.
module npff_div (
  input  logic               clk,
  input  logic               rst,
  input  npff_pkg::div_req_t req,
  output npff_pkg::div_rsp_t rsp
);
  import npff_pkg::*;

  logic        [62:0] nq;
  logic        [32:0] dmag;
  logic        [33:0] rem;
  logic        [33:0] trial;
  logic        [5:0]  cnt;
  logic               neg, busy, done;
  logic signed [63:0] nabs, dabs;
  logic               fits;

  always_comb begin
    nabs  = req.num[63] ? -req.num : req.num;
    dabs  = req.den[32] ? -64'(req.den) : 64'(req.den);
    trial = {rem[32:0], nq[62]};
    fits  = (trial >= {1'b0, dmag});
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      nq   <= nabs[62:0];
      dmag <= dabs[32:0];
      rem  <= '0;
      neg  <= req.num[63] ^ req.den[32];
      cnt  <= 6'd62;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, dmag}) : trial;
      nq  <= {nq[61:0], fits};
      cnt <= cnt - 6'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = neg ? -$signed({1'b0, nq}) : $signed({1'b0, nq});

endmodule

>>> src/npff_back.sv
// Back end: multiplies, divides, saturates and accumulates one species.
module npff_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic signed [31:0]               flow_velocity,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  npff_pkg::q_item_t                q_data,
  output npff_pkg::div_req_t               div_req,
  input  npff_pkg::div_rsp_t               div_rsp,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // species_flux, current_density
  output logic [npff_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tuser,   // distance_error
  output logic                             m_tlast    // is_last
);
  import npff_pkg::*;

  localparam logic [30:0]        P_MAX   = 31'h7FFF_FFFF;
  localparam logic signed [69:0] S_HI    = 70'sd4294967295;
  localparam logic signed [69:0] S_LO    = -70'sd4294967295;
  localparam logic signed [63:0] D_HI    = 64'sd281474976710656;
  localparam logic signed [63:0] D_LO    = -64'sd281474976710656;
  localparam logic signed [64:0] F_HI    = 65'sd2147483647;
  localparam logic signed [64:0] F_LO    = -65'sd2147483648;
  localparam logic signed [48:0] SUM_HI  = 49'sd140737488355327;
  localparam logic signed [48:0] SUM_LO  = -49'sd140737488355328;

  back_state_t        state, state_next;
  q_item_t            cur;
  logic        [61:0] pa;
  logic signed [64:0] cd;
  logic signed [63:0] advp;
  logic        [30:0] p;
  logic signed [32:0] s;
  logic signed [63:0] adv;
  logic signed [49:0] diff;
  logic signed [31:0] flux;
  logic signed [47:0] charge_flux_sum;
  logic               out_free, out_load;

  logic        [61:0] pa_sh;
  logic signed [64:0] cd_sh;
  logic signed [68:0] zcd;
  logic signed [69:0] s_wide;
  logic signed [64:0] prod;
  logic signed [63:0] negq;
  logic signed [64:0] fsum;
  logic signed [35:0] zflux;
  logic signed [48:0] acc;
  logic signed [47:0] acc_sat;

  // Datapath arithmetic between registers
  always_comb begin
    pa_sh  = pa >> FRAC_BITS;
    cd_sh  = cd >>> FRAC_BITS;
    zcd    = cur.z * cd_sh;
    s_wide = 70'(cur.dc) + 70'(zcd);
    prod   = $signed({1'b0, p}) * s;
    negq   = -div_rsp.quo;
    fsum   = 65'(diff) + 65'(adv);
    zflux  = cur.z * flux;
    acc    = 49'(charge_flux_sum) + 49'(zflux);
    if (acc > SUM_HI) acc_sat = SUM_HI[47:0];
    else if (acc < SUM_LO) acc_sat = SUM_LO[47:0];
    else acc_sat = acc[47:0];
  end

  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid) state_next = BK_MUL;
      BK_MUL:  state_next = BK_PRE;
      BK_PRE:  state_next = BK_PROD;
      BK_PROD: state_next = cur.derr ? BK_FIN : BK_DIV;
      BK_DIV:  if (div_rsp.done) state_next = BK_FIN;
      BK_FIN:  state_next = BK_OUT;
      BK_OUT:  if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop         = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = prod[63:0];
    div_req.den   = cur.ksi;
    out_load      = 1'b0;
    case (state)
      BK_IDLE: q_pop = q_valid;
      BK_PROD: div_req.start = !cur.derr;
      BK_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= BK_IDLE;
      m_tvalid        <= 1'b0;
      charge_flux_sum <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid        <= 1'b1;
        charge_flux_sum <= cur.last ? '0 : acc_sat;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers per step
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    if (state == BK_MUL) begin
      pa   <= cur.alpha * cur.dcoef;
      cd   <= cur.cf * cur.dphi;
      advp <= flow_velocity * cur.cf;
    end
    if (state == BK_PRE) begin
      p   <= (pa_sh > 62'(P_MAX)) ? P_MAX : pa_sh[30:0];
      adv <= advp >>> FRAC_BITS;
      if (s_wide > S_HI) s <= S_HI[32:0];
      else if (s_wide < S_LO) s <= S_LO[32:0];
      else s <= s_wide[32:0];
    end
    if (state == BK_PROD && cur.derr) diff <= '0;
    if (state == BK_DIV && div_rsp.done) begin
      if (negq > D_HI) diff <= D_HI[49:0];
      else if (negq < D_LO) diff <= D_LO[49:0];
      else diff <= negq[49:0];
    end
    if (state == BK_FIN) begin
      if (fsum > F_HI) flux <= F_HI[31:0];
      else if (fsum < F_LO) flux <= F_LO[31:0];
      else flux <= fsum[31:0];
    end
    if (out_load) begin
      m_tdata[31:0]  <= flux;
      m_tdata[79:32] <= cur.last ? acc_sat : '0;
      m_tlast        <= cur.last;
      m_tuser        <= cur.derr;
    end
  end

endmodule
